@@ rtl/core/rev_pkg.sv @@
// Shared types and constants for the rotary encoder value adjuster.
package rev_pkg;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CW    = 3'd1,
    EV_CCW   = 3'd2,
    EV_SHORT = 3'd3,
    EV_LONG  = 3'd4
  } rev_event_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_SIZE   = 3'd0,
    REG_UPPER_LIMIT = 3'd1,
    REG_LOWER_LIMIT = 3'd2,
    REG_SHORT_MIN   = 3'd3,
    REG_LONG_TICKS  = 3'd4
  } rev_reg_t;

  localparam logic [CodeW-1:0] CODE_CW  = 8'h42;
  localparam logic [CodeW-1:0] CODE_CCW = 8'h24;

  localparam logic [ValueW-1:0] STEP_RST  = 16'd1;
  localparam logic [ValueW-1:0] UPPER_RST = 16'd100;
  localparam logic [ValueW-1:0] LOWER_RST = 16'd0;
  localparam logic [ValueW-1:0] SHORT_RST = 16'd10;
  localparam logic [ValueW-1:0] LONG_RST  = 16'd2000;
  localparam logic [ValueW-1:0] HOLD_MAX  = 16'hFFFF;

  typedef struct packed {
    logic phase_cw;
    logic phase_ccw;
    logic button_level;
  } rev_in_t;

  typedef struct packed {
    rev_event_t         event_code;
    logic [ValueW-1:0]  current_value;
  } rev_out_t;

  typedef struct packed {
    logic [ValueW-1:0] step_size;
    logic [ValueW-1:0] upper_limit;
    logic [ValueW-1:0] lower_limit;
    logic [ValueW-1:0] short_press_min;
    logic [ValueW-1:0] long_press_ticks;
  } rev_cfg_t;

  typedef struct packed {
    logic [CodeW-1:0]  transition_code;
    logic              saved_cw;
    logic              saved_ccw;
    logic              moved_flag;
    logic [ValueW-1:0] hold_count;
    logic [ValueW-1:0] held_value;
  } rev_state_t;

endpackage

@@ rtl/core/rev_step.sv @@
// Per-tick next-state and event logic: button timing, quadrature decode, value update.
module rev_step (
  input  rev_pkg::rev_in_t    item,
  input  rev_pkg::rev_cfg_t   cfg,
  input  rev_pkg::rev_state_t state,
  output rev_pkg::rev_state_t state_next,
  output rev_pkg::rev_out_t   result
);

  rev_pkg::rev_event_t         btn_ev;
  rev_pkg::rev_event_t         rot_ev;
  rev_pkg::rev_event_t         ev;
  logic [rev_pkg::CodeW-1:0]   code_a;
  logic [rev_pkg::CodeW-1:0]   code_b;
  logic [rev_pkg::ValueW-1:0]  hold_inc;
  logic [rev_pkg::ValueW-1:0]  value_next;

  always_comb begin
    state_next = state;
    btn_ev     = rev_pkg::EV_NONE;
    rot_ev     = rev_pkg::EV_NONE;
    hold_inc   = state.hold_count;
    code_a     = '0;
    code_b     = '0;

    // button: low level means pressed
    if (!item.button_level) begin
      if (state.hold_count != rev_pkg::HOLD_MAX) begin
        hold_inc = state.hold_count + 16'd1;
      end
      state_next.hold_count = hold_inc;
      if (hold_inc >= cfg.long_press_ticks) begin
        btn_ev = rev_pkg::EV_LONG;
      end
    end else begin
      if (state.hold_count > cfg.short_press_min &&
          state.hold_count < cfg.long_press_ticks) begin
        btn_ev = rev_pkg::EV_SHORT;
      end
      state_next.hold_count = '0;
    end

    // quadrature decode; both high is the detent rest position
    if (item.phase_cw && item.phase_ccw) begin
      if (state.moved_flag) begin
        state_next.moved_flag = 1'b0;
        if (state.transition_code == rev_pkg::CODE_CW) begin
          rot_ev = rev_pkg::EV_CW;
        end else if (state.transition_code == rev_pkg::CODE_CCW) begin
          rot_ev = rev_pkg::EV_CCW;
        end
      end
      state_next.transition_code = '0;
      state_next.saved_cw        = 1'b1;
      state_next.saved_ccw       = 1'b1;
    end else begin
      state_next.moved_flag = 1'b1;
      if (item.phase_cw != state.saved_cw || item.phase_ccw != state.saved_ccw) begin
        code_a = (state.transition_code + {7'd0, item.phase_cw}) << 1;
        code_b = (code_a + {7'd0, item.phase_ccw}) << 1;
        state_next.saved_cw        = item.phase_cw;
        state_next.saved_ccw       = item.phase_ccw;
        state_next.transition_code = code_b;
      end
    end

    ev = (rot_ev != rev_pkg::EV_NONE) ? rot_ev : btn_ev;

    value_next = state.held_value;
    if (ev == rev_pkg::EV_CW) begin
      if (state.held_value < cfg.upper_limit) begin
        value_next = state.held_value + cfg.step_size;
      end else begin
        value_next = cfg.lower_limit;
      end
    end else if (ev == rev_pkg::EV_CCW) begin
      if (state.held_value > cfg.lower_limit) begin
        value_next = state.held_value - cfg.step_size;
      end else begin
        value_next = cfg.upper_limit;
      end
    end
    state_next.held_value = value_next;

    result.event_code    = ev;
    result.current_value = value_next;
  end

endmodule

@@ rtl/core/rotary_encoder_value_adjust.sv @@
// An accepted sample is held in the input register, then moves into the result register behind out_valid.
// Throughput: one sample per cycle; the input register refills while the result waits.
// The block stalls only when the result register is full and out_ready is low.
// Reset (rst, synchronous): config registers take their default values, decoder at rest
// with both saved phases high, hold count and held value zero, both stages empty.
module rotary_encoder_value_adjust (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rev_pkg::rev_in_t              in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rev_pkg::rev_out_t             out_item,
  input  logic                          cfg_we,
  input  logic [rev_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rev_pkg::ValueW-1:0]    cfg_data
);

  rev_pkg::rev_cfg_t   cfg;
  rev_pkg::rev_state_t state;
  rev_pkg::rev_state_t state_next;
  rev_pkg::rev_in_t    item;
  rev_pkg::rev_out_t   result;
  logic                item_valid;
  logic                advance;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size        <= rev_pkg::STEP_RST;
      cfg.upper_limit      <= rev_pkg::UPPER_RST;
      cfg.lower_limit      <= rev_pkg::LOWER_RST;
      cfg.short_press_min  <= rev_pkg::SHORT_RST;
      cfg.long_press_ticks <= rev_pkg::LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rev_pkg::REG_STEP_SIZE:   cfg.step_size        <= cfg_data;
        rev_pkg::REG_UPPER_LIMIT: cfg.upper_limit      <= cfg_data;
        rev_pkg::REG_LOWER_LIMIT: cfg.lower_limit      <= cfg_data;
        rev_pkg::REG_SHORT_MIN:   cfg.short_press_min  <= cfg_data;
        rev_pkg::REG_LONG_TICKS:  cfg.long_press_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

  rev_step u_step (
    .item       (item),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // tracking state commits as each sample moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.transition_code <= '0;
      state.saved_cw        <= 1'b1;
      state.saved_ccw       <= 1'b1;
      state.moved_flag      <= 1'b0;
      state.hold_count      <= '0;
      state.held_value      <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

@@ verif/rotary_encoder_value_adjust_test.sv @@
// Self-checking testbench for the rotary encoder value adjuster.
`timescale 1ns / 100ps

module rotary_encoder_value_adjust_test;

  localparam int unsigned STALL_LIMIT       = 5000;
  localparam int unsigned TICKS_PER_SETTING = 68;
  localparam int unsigned RANDOM_PLAN       = 7;
  localparam int unsigned DRILL_ROWS        = 30;

  // phase pairs {cw, ccw} of one detent, idle excluded
  localparam logic [5:0] CW_PATH  = 6'b10_00_01;
  localparam logic [5:0] CCW_PATH = 6'b01_00_10;

  localparam logic [rev_pkg::CfgIdxW-1:0] REG_SPARE     = 3'd5;
  localparam logic [rev_pkg::CfgIdxW-1:0] REG_SPARE_TOP = 3'd7;

  // long threshold used while the table runs
  localparam logic [rev_pkg::ValueW-1:0] DRILL_LONG = 16'd20;

  typedef struct packed {
    rev_pkg::rev_in_t    tick;
    logic [15:0]         reps;
    logic                known;
    rev_pkg::rev_event_t ev;
    logic [15:0]         val;
  } drill_row_t;

  // tick is {phase_cw, phase_ccw, button_level}
  localparam drill_row_t DRILL [DRILL_ROWS] = '{
    '{3'b111, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd0},
    '{3'b101, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd0},
    '{3'b001, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd0},
    '{3'b011, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd0},
    '{3'b111, 16'd1,    1'b1, rev_pkg::EV_CW,    16'd1},
    '{3'b011, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd1},
    '{3'b001, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd1},
    '{3'b101, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd1},
    '{3'b111, 16'd1,    1'b1, rev_pkg::EV_CCW,   16'd0},
    '{3'b011, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd0},
    '{3'b001, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd0},
    '{3'b101, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd0},
    '{3'b111, 16'd1,    1'b1, rev_pkg::EV_CCW,   16'd100},
    '{3'b101, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd100},
    '{3'b001, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd100},
    '{3'b011, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd100},
    '{3'b111, 16'd1,    1'b1, rev_pkg::EV_CW,    16'd0},
    '{3'b001, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd0},
    '{3'b111, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd0},
    '{3'b110, 16'd11,   1'b1, rev_pkg::EV_NONE,  16'd0},
    '{3'b111, 16'd1,    1'b1, rev_pkg::EV_SHORT, 16'd0},
    '{3'b100, 16'd1,    1'b0, rev_pkg::EV_NONE,  16'd0},
    '{3'b000, 16'd1,    1'b0, rev_pkg::EV_NONE,  16'd0},
    '{3'b010, 16'd9,    1'b0, rev_pkg::EV_NONE,  16'd0},
    '{3'b111, 16'd1,    1'b0, rev_pkg::EV_NONE,  16'd0},
    '{3'b110, 16'd10,   1'b1, rev_pkg::EV_NONE,  16'd1},
    '{3'b111, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd1},
    '{3'b110, 16'd19,   1'b1, rev_pkg::EV_NONE,  16'd1},
    '{3'b110, 16'd3,    1'b1, rev_pkg::EV_LONG,  16'd1},
    '{3'b111, 16'd1,    1'b1, rev_pkg::EV_NONE,  16'd1}
  };

  // step, upper, lower, short minimum, long ticks
  localparam rev_pkg::rev_cfg_t CFG_PLAN [9] = '{
    '{16'd1,     16'd100,   16'd0,     16'd3,     16'd12},
    '{16'hFFFF,  16'hFFFF,  16'd0,     16'd0,     16'd1},
    '{16'd0,     16'd0,     16'd0,     16'hFFFF,  16'd0},
    '{16'd7,     16'd20,    16'hFFFF,  16'd2,     16'd9},
    '{16'd4097,  16'd50000, 16'd1000,  16'd5,     16'd20},
    '{16'd1,     16'd3,     16'd1,     16'd1,     16'd6},
    '{16'hFFFF,  16'd10,    16'd20,    16'd0,     16'hFFFF},
    '{16'd0,     16'd0,     16'd0,     16'd0,     16'd1},
    '{16'd2,     16'hFFFF,  16'hFFFF,  16'd4,     16'd2}
  };

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  rev_pkg::rev_in_t             in_item   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  rev_pkg::rev_out_t            out_item;
  logic                         cfg_we    = 1'b0;
  logic [rev_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [rev_pkg::ValueW-1:0]   cfg_data  = '0;

  logic                 tag_known = 1'b0;
  rev_pkg::rev_out_t    tag_want  = '0;
  logic                 btn_now   = 1'b1;

  rev_pkg::rev_cfg_t    model_cfg;
  rev_pkg::rev_state_t  enc;
  rev_pkg::rev_out_t    pending_results [$];

  int unsigned errors        = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned btn_flip      = 8;
  int unsigned ticks_sent    = 0;

  rotary_encoder_value_adjust u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_model();
    model_cfg = '{rev_pkg::STEP_RST, rev_pkg::UPPER_RST, rev_pkg::LOWER_RST,
                  rev_pkg::SHORT_RST, rev_pkg::LONG_RST};
    enc = '0;
    enc.saved_cw  = 1'b1;
    enc.saved_ccw = 1'b1;
  endfunction

  function automatic void apply_reg(logic [rev_pkg::CfgIdxW-1:0] idx,
                                    logic [rev_pkg::ValueW-1:0] data);
    case (idx)
      rev_pkg::REG_STEP_SIZE:   model_cfg.step_size        = data;
      rev_pkg::REG_UPPER_LIMIT: model_cfg.upper_limit      = data;
      rev_pkg::REG_LOWER_LIMIT: model_cfg.lower_limit      = data;
      rev_pkg::REG_SHORT_MIN:   model_cfg.short_press_min  = data;
      rev_pkg::REG_LONG_TICKS:  model_cfg.long_press_ticks = data;
      default: ;
    endcase
  endfunction

  function automatic rev_pkg::rev_out_t advance_encoder(rev_pkg::rev_in_t s);
    rev_pkg::rev_event_t       ev;
    rev_pkg::rev_event_t       turn;
    logic [rev_pkg::CodeW-1:0] code;
    rev_pkg::rev_out_t         r;
    ev   = rev_pkg::EV_NONE;
    turn = rev_pkg::EV_NONE;
    if (!s.button_level) begin
      if (enc.hold_count != rev_pkg::HOLD_MAX) enc.hold_count = enc.hold_count + 16'd1;
      if (enc.hold_count >= model_cfg.long_press_ticks) ev = rev_pkg::EV_LONG;
    end else begin
      if (enc.hold_count > model_cfg.short_press_min &&
          enc.hold_count < model_cfg.long_press_ticks) ev = rev_pkg::EV_SHORT;
      enc.hold_count = '0;
    end
    if (s.phase_cw && s.phase_ccw) begin
      if (enc.moved_flag) begin
        enc.moved_flag = 1'b0;
        if (enc.transition_code == rev_pkg::CODE_CW) turn = rev_pkg::EV_CW;
        else if (enc.transition_code == rev_pkg::CODE_CCW) turn = rev_pkg::EV_CCW;
      end
      enc.transition_code = '0;
      enc.saved_cw        = 1'b1;
      enc.saved_ccw       = 1'b1;
    end else begin
      enc.moved_flag = 1'b1;
      if (s.phase_cw != enc.saved_cw || s.phase_ccw != enc.saved_ccw) begin
        enc.saved_cw  = s.phase_cw;
        enc.saved_ccw = s.phase_ccw;
        code = enc.transition_code + {7'd0, s.phase_cw};
        code = code << 1;
        code = code + {7'd0, s.phase_ccw};
        enc.transition_code = code << 1;
      end
    end
    if (turn != rev_pkg::EV_NONE) ev = turn;
    if (ev == rev_pkg::EV_CW) begin
      if (enc.held_value < model_cfg.upper_limit)
        enc.held_value = enc.held_value + model_cfg.step_size;
      else
        enc.held_value = model_cfg.lower_limit;
    end else if (ev == rev_pkg::EV_CCW) begin
      if (enc.held_value > model_cfg.lower_limit)
        enc.held_value = enc.held_value - model_cfg.step_size;
      else
        enc.held_value = model_cfg.upper_limit;
    end
    r.event_code    = ev;
    r.current_value = enc.held_value;
    return r;
  endfunction

  task automatic report_fault(input string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : scoreboard
    rev_pkg::rev_out_t want;
    if (rst) begin
      reset_model();
      pending_results.delete();
    end else begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_fault("result transfer with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (out_item.event_code !== want.event_code)
            report_fault($sformatf("event_code got %0d want %0d",
                                   out_item.event_code, want.event_code));
          if (out_item.current_value !== want.current_value)
            report_fault($sformatf("current_value got %0d want %0d",
                                   out_item.current_value, want.current_value));
        end
      end
      if (in_valid && in_ready) begin
        want = advance_encoder(in_item);
        pending_results.push_back(tag_known ? tag_want : want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_sample(input rev_pkg::rev_in_t s, input logic known,
                             input rev_pkg::rev_out_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_item   <= s;
    tag_known <= known;
    tag_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender holds off until every result is back, then the block is idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rev_pkg::CfgIdxW-1:0] idx,
                           input logic [rev_pkg::ValueW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_regs(input rev_pkg::rev_cfg_t c);
    write_reg(rev_pkg::REG_STEP_SIZE,   c.step_size);
    write_reg(rev_pkg::REG_UPPER_LIMIT, c.upper_limit);
    write_reg(rev_pkg::REG_LOWER_LIMIT, c.lower_limit);
    write_reg(rev_pkg::REG_SHORT_MIN,   c.short_press_min);
    write_reg(rev_pkg::REG_LONG_TICKS,  c.long_press_ticks);
    write_reg(REG_SPARE,                16'($urandom));
    write_reg(REG_SPARE_TOP,            16'($urandom));
  endtask

  task automatic pin_tick(input logic cw, input logic ccw);
    rev_pkg::rev_in_t s;
    if ($urandom_range(btn_flip) == 0) btn_now = ~btn_now;
    s.phase_cw     = cw;
    s.phase_ccw    = ccw;
    s.button_level = btn_now;
    send_sample(s, 1'b0, '0);
    ticks_sent++;
  endtask

  task automatic detent(input logic clockwise);
    logic [5:0] path;
    logic [1:0] pair;
    int         i;
    path = clockwise ? CW_PATH : CCW_PATH;
    for (i = 0; i < 3; i++) begin
      pair = path[5-2*i -: 2];
      pin_tick(pair[1], pair[0]);
      if ($urandom_range(3) == 0) pin_tick(pair[1], pair[0]);
    end
    pin_tick(1'b1, 1'b1);
  endtask

  task automatic random_gesture();
    int unsigned kind;
    int unsigned n;
    int unsigned i;
    logic [1:0]  pair;
    kind = $urandom_range(15);
    if (kind <= 5) begin
      detent(1'b1);
    end else if (kind <= 10) begin
      detent(1'b0);
    end else if (kind <= 12) begin
      // broken detent: wanders off idle and back
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
        pair = 2'($urandom_range(2));
        pin_tick(pair[1], pair[0]);
      end
      pin_tick(1'b1, 1'b1);
    end else if (kind <= 14) begin
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) begin
        pair = 2'($urandom_range(3));
        pin_tick(pair[1], pair[0]);
      end
    end else begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) pin_tick(1'b1, 1'b1);
    end
  endtask

  initial begin : run
    rev_pkg::rev_cfg_t  plan;
    rev_pkg::rev_out_t  want;
    int unsigned        p;
    int unsigned        k;
    int unsigned        r;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // shorter long threshold keeps the long press rows brief
    write_reg(rev_pkg::REG_LONG_TICKS, DRILL_LONG);

    send_idle_pct = 28;
    recv_idle_pct = 79;
    for (r = 0; r < DRILL_ROWS; r++) begin
      want.event_code    = DRILL[r].ev;
      want.current_value = DRILL[r].val;
      repeat (DRILL[r].reps) send_sample(DRILL[r].tick, DRILL[r].known, want);
    end
    settle();

    for (p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 28 : (p == 1) ? 79 : 0;
      recv_idle_pct = (p == 0) ? 79 : (p == 1) ? 28 : 0;
      for (k = 0; k < 3; k++) begin
        plan = CFG_PLAN[p*3+k];
        if (p*3+k == RANDOM_PLAN) begin
          plan.step_size        = 16'($urandom);
          plan.upper_limit      = 16'($urandom);
          plan.lower_limit      = 16'($urandom);
          plan.short_press_min  = 16'($urandom_range(0, 8));
          plan.long_press_ticks = 16'($urandom_range(1, 30));
        end
        program_regs(plan);
        btn_flip   = $urandom_range(2, 12);
        ticks_sent = 0;
        while (ticks_sent < TICKS_PER_SETTING) begin
          random_gesture();
          if ($urandom_range(40) == 0) settle();
        end
        settle();
      end
    end

    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
